// ===== rtl/bwua_pkg.sv =====
// Shared types, register indexes and saturating helpers for the barycenter weight update block.
package bwua_pkg;

  localparam logic [2:0] REG_NUM_POINTS = 3'd0;
  localparam logic [2:0] REG_HALF_STEP  = 3'd1;
  localparam logic [2:0] REG_STEP_P2W   = 3'd2;
  localparam logic [2:0] REG_RECIP      = 3'd3;
  localparam logic [2:0] REG_WIN_WIDTH  = 3'd4;

  typedef struct packed {
    logic vld;
    logic first;
  } scan_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] inc16(input logic [15:0] c);
    return (c == 16'hFFFF) ? c : c + 16'd1;
  endfunction

  function automatic logic [15:0] dec16(input logic [15:0] c);
    return (c == 16'h0000) ? c : c - 16'd1;
  endfunction

endpackage

// ===== rtl/bwua_ram.sv =====
// Generic single-port RAM with registered read.
module bwua_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/bwua_argmin.sv =====
// Running minimum tracker fed one weight per cycle during the scan.
module bwua_argmin #(
  parameter int IW = 10
) (
  input  logic                clk,
  input  bwua_pkg::scan_ctl_t ctl,
  input  logic signed [31:0]  data,
  input  logic [IW-1:0]       idx,
  output logic [IW-1:0]       best_idx
);

  logic signed [31:0] min_r;
  logic [IW-1:0]      idx_r;

  // Strict less-than keeps the lowest index on ties.
  always_ff @(posedge clk) begin
    if (ctl.vld && (ctl.first || data < min_r)) begin
      min_r <= data;
      idx_r <= idx;
    end
  end

  assign best_idx = idx_r;

endmodule

// ===== rtl/barycenter_weight_update_argmin_core.sv =====
// Top level of the barycenter weight update with running argmin.
//
//  Channel | Direction | Handshake          | Payload
//  in_     | input     | in_tvalid/tready   | atom_index, worker_value, worker_id
//  out_    | output    | out_tvalid/tready  | reply_index, objective_estimate, reply_count
//  cfg_    | input     | cfg_we             | cfg_index selects, cfg_wdata value
//
// With the window off a word passes through accept, index wrap, four read-modify-write
// steps, a count read and the output step; then one stored weight per cycle is read
// through the single weight RAM port, and the scan ends by latching the new best atom.
// A window entry adds a slot write, a removal a slot read and a hit count read and write.
// After reset a clearing pass over every address zeroes weights and hit counts.
// A result not yet taken holds the block in the output step; the scan of a word runs
// while its result waits, and the next word is accepted once the scan is done.
module barycenter_weight_update_argmin_core #(
  parameter int ATOMS_MAX    = 1024,
  parameter int WORKERS_MAX  = 16,
  parameter int WINDOW_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // atom_index[9:0], worker_value[41:10], worker_id[45:42]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // reply_index[9:0], objective_estimate[41:10],
                                  // reply_count[57:42]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_wdata
);

  localparam int AW  = $clog2(ATOMS_MAX);
  localparam int WKW = (WORKERS_MAX > 1) ? $clog2(WORKERS_MAX) : 1;
  localparam int WDW = $clog2(WINDOW_DEPTH);
  localparam int AIW = (AW > 10) ? AW : 10;
  localparam int WIW = (WKW > 4) ? WKW : 4;
  localparam int FW  = AW + WKW;

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_MOD   = 5'd2;
  localparam logic [4:0] S_RDB   = 5'd3;
  localparam logic [4:0] S_UPB   = 5'd4;
  localparam logic [4:0] S_RDA   = 5'd5;
  localparam logic [4:0] S_UPA   = 5'd6;
  localparam logic [4:0] S_WWR   = 5'd7;
  localparam logic [4:0] S_WRD   = 5'd8;
  localparam logic [4:0] S_WHR   = 5'd9;
  localparam logic [4:0] S_WHW   = 5'd10;
  localparam logic [4:0] S_RDC   = 5'd11;
  localparam logic [4:0] S_OUT   = 5'd12;
  localparam logic [4:0] S_SCAN  = 5'd13;
  localparam logic [4:0] S_SCANE = 5'd14;
  localparam logic [4:0] S_FIN   = 5'd15;

  logic [4:0] state_r, state_nxt;

  logic [10:0] num_points_r;
  logic [30:0] half_step_r;
  logic [30:0] step_p2w_r;
  logic [16:0] recip_r;
  logic [11:0] win_width_r;

  logic [AIW-1:0]     atom_raw_r;
  logic [WIW-1:0]     worker_raw_r;
  logic signed [31:0] value_r;
  logic [AW-1:0]      best_r;
  logic signed [49:0] prod_r;
  logic signed [31:0] est_r;
  logic [AW-1:0]      oa_r;
  logic [AW-1:0]      clr_cnt_r;
  logic [AW-1:0]      scan_cnt_r;
  logic [AW-1:0]      rd_idx_r;
  logic               rd_pend_r;
  logic [WDW-1:0]     head_r;
  logic [WDW:0]       fill_r;
  logic [15:0]        worker_hits_r [WORKERS_MAX];

  logic        out_valid_r;
  logic [9:0]  out_index_r;
  logic [31:0] out_est_r;
  logic [15:0] out_count_r;

  // RAM ports
  logic          w_we, w_re, h_we, h_re, f_we, f_re;
  logic [AW-1:0] w_addr, h_addr;
  logic signed [31:0] w_wdata, w_rdata;
  logic [15:0]   h_wdata, h_rdata;
  logic [WDW-1:0] f_addr;
  logic [FW-1:0]  f_wdata, f_rdata;

  logic [AW-1:0]  atom;
  logic [WKW-1:0] worker;
  logic           atom_ok, worker_ok;
  logic [16:0]    win_eff;
  logic [AW-1:0]  npts_m1;
  logic [WDW+1:0] slot_sum;
  logic [WDW-1:0] slot;
  logic [WDW-1:0] head_inc;
  logic [WDW:0]   fill_inc;
  logic [AW-1:0]  old_atom;
  logic [WKW-1:0] old_worker;
  logic [AW-1:0]  scan_best;
  bwua_pkg::scan_ctl_t scan_ctl;

  assign atom      = atom_raw_r[AW-1:0];
  assign worker    = worker_raw_r[WKW-1:0];
  assign atom_ok   = 18'(atom_raw_r) < 18'(ATOMS_MAX);
  assign worker_ok = 10'(worker_raw_r) < 10'(WORKERS_MAX);
  assign win_eff   = (17'(win_width_r) > 17'(WINDOW_DEPTH - 1)) ?
                     17'(WINDOW_DEPTH - 1) : 17'(win_width_r);
  assign old_atom   = f_rdata[FW-1:WKW];
  assign old_worker = f_rdata[WKW-1:0];
  assign fill_inc   = fill_r + 1'b1;

  always_comb begin
    logic [17:0] np;
    np = 18'(num_points_r);
    if (np == 18'd0) begin
      np = 18'd1;
    end else if (np > 18'(ATOMS_MAX)) begin
      np = 18'(ATOMS_MAX);
    end
    npts_m1 = AW'(np - 18'd1);
  end

  always_comb begin
    slot_sum = (WDW+2)'(head_r) + (WDW+2)'(fill_r);
    if (slot_sum >= (WDW+2)'(WINDOW_DEPTH)) begin
      slot_sum = slot_sum - (WDW+2)'(WINDOW_DEPTH);
    end
    slot = slot_sum[WDW-1:0];
    head_inc = ((WDW+1)'(head_r) + 1'b1 == (WDW+1)'(WINDOW_DEPTH)) ? '0 : head_r + 1'b1;
  end

  always_comb begin
    w_we = 1'b0; w_re = 1'b0; w_addr = best_r; w_wdata = '0;
    h_we = 1'b0; h_re = 1'b0; h_addr = best_r; h_wdata = '0;
    f_we = 1'b0; f_re = 1'b0; f_addr = head_r; f_wdata = {best_r, worker};
    case (state_r)
      S_CLR: begin
        w_we = 1'b1; w_addr = clr_cnt_r;
        h_we = 1'b1; h_addr = clr_cnt_r;
      end
      S_RDB: begin
        w_re = 1'b1; h_re = 1'b1;
      end
      S_UPB: begin
        w_we = 1'b1;
        w_wdata = bwua_pkg::sat32(36'(w_rdata) + 36'(step_p2w_r));
        h_we = 1'b1;
        h_wdata = bwua_pkg::inc16(h_rdata);
      end
      S_RDA: begin
        w_re = 1'b1; w_addr = atom;
      end
      S_UPA: begin
        w_we = 1'b1; w_addr = atom;
        w_wdata = bwua_pkg::sat32(36'(w_rdata) - 36'(half_step_r));
      end
      S_WWR: begin
        f_we = 1'b1; f_addr = slot;
      end
      S_WRD: begin
        f_re = 1'b1;
      end
      S_WHR: begin
        h_re = 1'b1; h_addr = old_atom;
      end
      S_WHW: begin
        h_we = 1'b1; h_addr = oa_r;
        h_wdata = bwua_pkg::dec16(h_rdata);
      end
      S_RDC: begin
        h_re = 1'b1;
      end
      S_SCAN: begin
        w_re = 1'b1; w_addr = scan_cnt_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:   if (clr_cnt_r == AW'(ATOMS_MAX - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_tvalid) state_nxt = S_MOD;
      S_MOD:   if (atom_ok && worker_ok) state_nxt = S_RDB;
      S_RDB:   state_nxt = S_UPB;
      S_UPB:   state_nxt = S_RDA;
      S_RDA:   state_nxt = S_UPA;
      S_UPA:   state_nxt = (win_eff != 17'd0) ? S_WWR : S_RDC;
      S_WWR:   state_nxt = (17'(fill_inc) > win_eff) ? S_WRD : S_RDC;
      S_WRD:   state_nxt = S_WHR;
      S_WHR:   state_nxt = S_WHW;
      S_WHW:   state_nxt = S_RDC;
      S_RDC:   state_nxt = S_OUT;
      S_OUT:   if (!out_valid_r || out_tready) state_nxt = S_SCAN;
      S_SCAN:  if (scan_cnt_r == npts_m1) state_nxt = S_SCANE;
      S_SCANE: state_nxt = S_FIN;
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      num_points_r <= 11'd1024;
      half_step_r  <= 31'd32768;
      step_p2w_r   <= 31'd4096;
      recip_r      <= 17'd16384;
      win_width_r  <= 12'd0;
      best_r       <= '0;
      head_r       <= '0;
      fill_r       <= '0;
      clr_cnt_r    <= '0;
      scan_cnt_r   <= '0;
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < WORKERS_MAX; i++) begin
        worker_hits_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          bwua_pkg::REG_NUM_POINTS: num_points_r <= cfg_wdata[10:0];
          bwua_pkg::REG_HALF_STEP:  half_step_r  <= cfg_wdata;
          bwua_pkg::REG_STEP_P2W:   step_p2w_r   <= cfg_wdata;
          bwua_pkg::REG_RECIP:      recip_r      <= cfg_wdata[16:0];
          bwua_pkg::REG_WIN_WIDTH:  win_width_r  <= cfg_wdata[11:0];
          default: begin
          end
        endcase
      end
      if ((state_r == S_OUT) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      rd_pend_r <= (state_r == S_SCAN);
      rd_idx_r  <= scan_cnt_r;
      case (state_r)
        S_CLR: clr_cnt_r <= clr_cnt_r + 1'b1;
        S_IDLE: begin
          atom_raw_r   <= AIW'(in_tdata[9:0]);
          value_r      <= in_tdata[41:10];
          worker_raw_r <= WIW'(in_tdata[45:42]);
        end
        S_MOD: begin
          // Index wrap by repeated subtraction of the table size.
          if (!atom_ok) atom_raw_r <= atom_raw_r - AIW'(ATOMS_MAX);
          if (!worker_ok) worker_raw_r <= worker_raw_r - WIW'(WORKERS_MAX);
        end
        S_UPB: begin
          prod_r <= w_rdata * $signed({1'b0, recip_r});
          worker_hits_r[worker] <= bwua_pkg::inc16(worker_hits_r[worker]);
        end
        S_RDA: est_r <= bwua_pkg::sat32(36'(value_r) + 36'(prod_r >>> 16));
        S_WWR: fill_r <= fill_inc;
        S_WHR: begin
          oa_r <= old_atom;
          worker_hits_r[old_worker] <= bwua_pkg::dec16(worker_hits_r[old_worker]);
        end
        S_WHW: begin
          head_r <= head_inc;
          fill_r <= fill_r - 1'b1;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_index_r <= 10'(best_r);
            out_est_r   <= est_r;
            out_count_r <= h_rdata;
            scan_cnt_r  <= '0;
          end
        end
        S_SCAN: scan_cnt_r <= scan_cnt_r + 1'b1;
        S_FIN:  best_r <= scan_best;
        default: begin
        end
      endcase
    end
  end

  assign scan_ctl.vld   = rd_pend_r;
  assign scan_ctl.first = (rd_idx_r == '0);

  bwua_ram #(.WIDTH(32), .DEPTH(ATOMS_MAX)) u_weights (
    .clk(clk), .we(w_we), .re(w_re), .addr(w_addr), .wdata(w_wdata), .rdata(w_rdata)
  );

  bwua_ram #(.WIDTH(16), .DEPTH(ATOMS_MAX)) u_hits (
    .clk(clk), .we(h_we), .re(h_re), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata)
  );

  bwua_ram #(.WIDTH(FW), .DEPTH(WINDOW_DEPTH)) u_window (
    .clk(clk), .we(f_we), .re(f_re), .addr(f_addr), .wdata(f_wdata), .rdata(f_rdata)
  );

  bwua_argmin #(.IW(AW)) u_argmin (
    .clk(clk), .ctl(scan_ctl), .data(w_rdata), .idx(rd_idx_r), .best_idx(scan_best)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_count_r, out_est_r, out_index_r};

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted on two cycles in a row");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (17'(fill_r) < 17'(WINDOW_DEPTH)))
    else $error("window fill beyond depth");

  a_best_range: assert property (@(posedge clk) disable iff (!rst_n)
    18'(best_r) < 18'(ATOMS_MAX))
    else $error("best atom out of range");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result raised outside the output step");

endmodule

// ===== dv/barycenter_weight_update_argmin_core_test.sv =====
// Self-checking testbench for the barycenter weight update argmin core.
`timescale 1ns / 100ps

module barycenter_weight_update_argmin_core_test;

  localparam int ATOMS       = 1024;
  localparam int WORKERS     = 16;
  localparam int WIN_DEPTH   = 4096;
  localparam int SETTLE      = 1100;
  localparam int STALL_LIMIT = 50000;
  localparam int HOLD_CYCLES = 1500;

  typedef struct {
    logic [9:0]         atom;
    logic signed [31:0] estimate;
    logic [15:0]        count;
  } reply_t;

  class weight_argmin_model;
    int          weights [ATOMS];
    bit [15:0]   atom_cnt [ATOMS];
    bit [15:0]   worker_cnt [WORKERS];
    bit [9:0]    hist_atom [WIN_DEPTH];
    bit [3:0]    hist_worker [WIN_DEPTH];
    int unsigned head, fill;
    bit [9:0]    best;
    int unsigned npoints, half, step_up, recip, win;
    reply_t      pending_replies [$];
    int          errors;

    function new();
      foreach (weights[i]) begin
        weights[i] = 0;
        atom_cnt[i] = 0;
      end
      foreach (worker_cnt[i]) worker_cnt[i] = 0;
      head = 0;
      fill = 0;
      best = 0;
      npoints = 1024;
      half = 32768;
      step_up = 4096;
      recip = 16384;
      win = 0;
      errors = 0;
    endfunction

    function int clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return int'(v);
    endfunction

    function bit [15:0] up16(bit [15:0] c);
      return (c == 16'hFFFF) ? c : c + 16'd1;
    endfunction

    function bit [15:0] down16(bit [15:0] c);
      return (c == 16'h0000) ? c : c - 16'd1;
    endfunction

    function void set_reg(logic [2:0] idx, logic [30:0] val);
      case (idx)
        bwua_pkg::REG_NUM_POINTS: npoints = val[10:0];
        bwua_pkg::REG_HALF_STEP:  half    = val[30:0];
        bwua_pkg::REG_STEP_P2W:   step_up = val[30:0];
        bwua_pkg::REG_RECIP:      recip   = val[16:0];
        bwua_pkg::REG_WIN_WIDTH:  win     = val[11:0];
        default: ;
      endcase
    endfunction

    function void note_input(bit [9:0] atom, bit [31:0] value, bit [3:0] worker);
      bit [9:0]    b;
      longint      prod, est;
      int unsigned width, slot, npts, i;
      int          minw;
      bit [9:0]    mini;
      reply_t      r;
      b = best;
      // Arithmetic shift of the product is a floor division by 65536.
      prod = longint'(weights[b]) * longint'(recip);
      est = longint'($signed(value)) + (prod >>> 16);
      atom_cnt[b] = up16(atom_cnt[b]);
      worker_cnt[worker] = up16(worker_cnt[worker]);
      weights[b] = clip32(longint'(weights[b]) + longint'(step_up));
      weights[atom] = clip32(longint'(weights[atom]) - longint'(half));
      width = (win > WIN_DEPTH - 1) ? WIN_DEPTH - 1 : win;
      if (width > 0) begin
        slot = (head + fill) % WIN_DEPTH;
        hist_atom[slot] = b;
        hist_worker[slot] = worker;
        fill++;
        if (fill > width) begin
          atom_cnt[hist_atom[head]] = down16(atom_cnt[hist_atom[head]]);
          worker_cnt[hist_worker[head]] = down16(worker_cnt[hist_worker[head]]);
          head = (head + 1) % WIN_DEPTH;
          fill--;
        end
      end
      r.atom = b;
      r.estimate = clip32(est);
      r.count = atom_cnt[b];
      pending_replies = {pending_replies, r};
      npts = (npoints == 0) ? 1 : ((npoints > ATOMS) ? ATOMS : npoints);
      minw = weights[0];
      mini = 0;
      for (i = 1; i < npts; i++) begin
        if (weights[i] < minw) begin
          minw = weights[i];
          mini = 10'(i);
        end
      end
      best = mini;
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [63:0] data);
      reply_t r;
      if (pending_replies.size() == 0) begin
        report($sformatf("unexpected word %h", data));
      end else begin
        r = pending_replies.pop_front();
        if (data[9:0] !== r.atom)
          report($sformatf("reply_index %0d, wanted %0d", data[9:0], r.atom));
        if (data[41:10] !== r.estimate)
          report($sformatf("objective_estimate %h, wanted %h", data[41:10], r.estimate));
        if (data[57:42] !== r.count)
          report($sformatf("reply_count %0d, wanted %0d", data[57:42], r.count));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // atom_index[9:0], worker_value[41:10], worker_id[45:42]
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // reply_index[9:0], objective_estimate[41:10], reply_count[57:42]
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [30:0] cfg_wdata;

  weight_argmin_model model;
  bit hold_request;
  bit no_gaps;
  int idle_cycles;

  barycenter_weight_update_argmin_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  task send_word(bit [9:0] atom, bit [31:0] value, bit [3:0] worker);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, worker, value, atom};
    do @(posedge clk); while (!in_tready);
    model.note_input(atom, value, worker);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task write_reg(logic [2:0] idx, logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    model.set_reg(idx, val);
  endtask

  // Waits for every reply, then lets the trailing scan finish.
  task drain();
    in_tvalid <= 1'b0;
    while (model.pending_replies.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task configure(int np, int hs, int sp, int rc, int ww);
    drain();
    write_reg(bwua_pkg::REG_NUM_POINTS, 31'(np));
    write_reg(bwua_pkg::REG_HALF_STEP, 31'(hs));
    write_reg(bwua_pkg::REG_STEP_P2W, 31'(sp));
    write_reg(bwua_pkg::REG_RECIP, 31'(rc));
    write_reg(bwua_pkg::REG_WIN_WIDTH, 31'(ww));
  endtask

  function int pick_step();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 32'h7FFF_FFFF;
    return $urandom_range(0, 1 << 18);
  endfunction

  // Receiver: random back-pressure plus one requested long hold-off.
  initial begin
    int stall;
    stall = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) model.check_result(out_tdata);
      if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (!no_gaps && $urandom_range(0, 99) < 20) begin
        stall = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int np, items, r, ww;
    model = new();
    hold_request = 1'b0;
    no_gaps = 1'b0;
    idle_cycles = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: field extremes.
    send_word(10'd0, 32'h7FFF_FFFF, 4'd0);
    send_word(10'd1023, 32'h8000_0000, 4'd15);
    send_word(10'd1023, 32'h0000_0000, 4'd5);
    send_word(10'd512, 32'hFFFF_FFFF, 4'd10);
    send_word(10'd341, 32'h5555_5555, 4'd3);
    send_word(10'd682, 32'hAAAA_AAAA, 4'd12);

    // Extreme steps with a single scanned atom saturate weights and the estimate.
    configure(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 65536, 4095);
    send_word(10'd0, 32'h7FFF_FFFF, 4'd1);
    send_word(10'd7, 32'h7FFF_FFFF, 4'd2);
    send_word(10'd7, 32'h7FFF_FFFF, 4'd2);
    send_word(10'd7, 32'h8000_0000, 4'd15);
    send_word(10'd0, 32'h8000_0000, 4'd0);
    send_word(10'd0, 32'h8000_0000, 4'd0);

    // Oversized point count, tiny window that shrinks next phase.
    configure(2047, 70000, 300, 0, 5);
    send_word(10'd1023, 32'h1234_5678, 4'd9);
    send_word(10'd900, 32'h0, 4'd4);
    send_word(10'd3, 32'h8765_4321, 4'd4);

    configure(4, 1000, 500, 1, 2);
    send_word(10'd3, 32'h0001_0000, 4'd0);
    send_word(10'd4, 32'h0001_0000, 4'd1);
    send_word(10'd2, 32'h0001_0000, 4'd2);
    send_word(10'd1, 32'h0001_0000, 4'd3);
    configure(4, 1000, 500, 65535, 0);
    send_word(10'd1, 32'hFFFF_0000, 4'd6);

    for (int phase = 0; phase < 16; phase++) begin
      r = $urandom_range(0, 9);
      if (r == 0) np = 0;
      else if (r == 1) np = (phase % 2) ? 1024 : 2047;
      else np = $urandom_range(1, 40);
      r = $urandom_range(0, 5);
      ww = (r == 0) ? 0 : (r == 1) ? 4095 : (r == 2) ? $urandom_range(1, 4095)
         : $urandom_range(1, 8);
      r = $urandom_range(0, 9);
      configure(np, pick_step(), pick_step(),
                (r == 0) ? 0 : (r == 1) ? 65536 : $urandom_range(0, 65536), ww);
      items = (np == 0 || np > 40) ? 8 : 41;
      no_gaps = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        no_gaps = 1'b0;
        hold_request = 1'b1;
      end
      for (int k = 0; k < items; k++) begin
        int lim;
        lim = (np == 0) ? 1 : (np > ATOMS) ? ATOMS : np;
        send_word(10'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                  : $urandom_range(0, lim)),
                  32'(($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 1 << 20)),
                  4'($urandom_range(0, 15)));
      end
      no_gaps = 1'b0;
    end

    drain();
    if (model.pending_replies.size() > 0)
      model.report($sformatf("%0d replies never came", model.pending_replies.size()));
    if (model.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== barycenter_weight_update_argmin_core.f =====
rtl/bwua_pkg.sv
rtl/bwua_ram.sv
rtl/bwua_argmin.sv
rtl/barycenter_weight_update_argmin_core.sv
dv/barycenter_weight_update_argmin_core_test.sv
